[rtl/aspdm_pkg.sv]
// Shared widths, register codes, item types and helpers of the smoothing and peak display map.
package aspdm_pkg;

    localparam int SAMPLE_BITS       = 16;
    localparam int FILTER_EXTRA_BITS = 16;
    localparam int ACCEL_FRAC_BITS   = SAMPLE_BITS - 4;
    localparam int GAIN_FRAC_BITS    = 8;

    localparam int WEIGHT_BITS = 16;
    localparam int GAIN_BITS   = 16;
    localparam int LIMIT_BITS  = 9;
    localparam int PEAK_BITS   = SAMPLE_BITS - 1;
    localparam int OFFSET_BITS = LIMIT_BITS + 1;
    localparam int COLOR_BITS  = 8;

    // filter datapath
    localparam int FILT_BITS    = SAMPLE_BITS + FILTER_EXTRA_BITS;
    localparam int DIFF_BITS    = FILT_BITS + 1;
    localparam int PROD_BITS    = DIFF_BITS + WEIGHT_BITS;
    localparam int STEP_BITS    = PROD_BITS + 1 - WEIGHT_BITS;
    localparam int WEIGHT_ROUND = (1 << WEIGHT_BITS) - 1;

    // gain datapath
    localparam int GP_BITS      = FILT_BITS + GAIN_BITS;
    localparam int OFFSET_SHIFT = ACCEL_FRAC_BITS + FILTER_EXTRA_BITS + GAIN_FRAC_BITS;
    localparam int PIX_BITS     = GP_BITS - OFFSET_SHIFT;

    // colour datapath
    localparam int COLOR_MAX    = (1 << COLOR_BITS) - 1;
    localparam int COLOR_MAX_SQ = COLOR_MAX * COLOR_MAX;
    localparam int SQ_BITS      = 2 * LIMIT_BITS;
    localparam int SUM_BITS     = SQ_BITS + 1;
    localparam int RHS_BITS     = SUM_BITS + 2 * COLOR_BITS;
    localparam int CPROD_BITS   = COLOR_BITS + LIMIT_BITS;
    localparam int CSQ_BITS     = 2 * CPROD_BITS;
    localparam int RBIT_BITS    = $clog2(COLOR_BITS);

    // ports
    localparam int IN_RAW_BITS   = 3 * SAMPLE_BITS;
    localparam int IN_DATA_BITS  = ((IN_RAW_BITS + 7) / 8) * 8;
    localparam int OUT_RAW_BITS  = 3 * PEAK_BITS + 2 * OFFSET_BITS + 2 * COLOR_BITS;
    localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCOUNT_BITS = $clog2(QUEUE_DEPTH + 1);

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WEIGHT = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GAIN   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LIMIT  = 2'd2;

    localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET = 16'd9830;
    localparam logic [GAIN_BITS-1:0]   GAIN_RESET   = 16'd20480;
    localparam logic [LIMIT_BITS-1:0]  LIMIT_RESET  = 9'd200;

    typedef struct packed {
        logic signed [OFFSET_BITS-1:0] offset_y;
        logic signed [OFFSET_BITS-1:0] offset_x;
        logic [PEAK_BITS-1:0]          peak_abs_z;
        logic [PEAK_BITS-1:0]          peak_abs_y;
        logic [PEAK_BITS-1:0]          peak_abs_x;
    } entry_t;

    typedef struct packed {
        logic [COLOR_BITS-1:0]         color_green;
        logic [COLOR_BITS-1:0]         color_red;
        logic signed [OFFSET_BITS-1:0] offset_y;
        logic signed [OFFSET_BITS-1:0] offset_x;
        logic [PEAK_BITS-1:0]          peak_abs_z;
        logic [PEAK_BITS-1:0]          peak_abs_y;
        logic [PEAK_BITS-1:0]          peak_abs_x;
    } result_t;

    // absolute value, most negative code saturates
    function automatic logic [PEAK_BITS-1:0] abs_sat(input logic signed [SAMPLE_BITS-1:0] v);
        logic [SAMPLE_BITS-1:0] mag;
        mag = v[SAMPLE_BITS-1] ? $unsigned(-v) : $unsigned(v);
        return mag[SAMPLE_BITS-1] ? {PEAK_BITS{1'b1}} : mag[PEAK_BITS-1:0];
    endfunction

endpackage

[rtl/aspdm_front.sv]
// Front end: sample intake, peak hold, X/Y low-pass filter and pixel offset clamp.
module aspdm_front (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [aspdm_pkg::IN_DATA_BITS-1:0]     s_tdata,
    input  logic                                   s_tuser,
    input  logic [aspdm_pkg::WEIGHT_BITS-1:0]      weight,
    input  logic [aspdm_pkg::GAIN_BITS-1:0]        gain,
    input  logic [aspdm_pkg::LIMIT_BITS-1:0]       limit,
    output logic                                   q_valid,
    input  logic                                   q_ready,
    output aspdm_pkg::entry_t                      q_data
);

    typedef enum logic [2:0] {F_IDLE, F_MUL, F_UPD, F_GAIN, F_PUSH} fstate_t;

    fstate_t state_reg;

    logic [aspdm_pkg::PEAK_BITS-1:0]          peak_reg   [3];
    logic signed [aspdm_pkg::FILT_BITS-1:0]   filt_reg   [2];
    logic signed [aspdm_pkg::SAMPLE_BITS-1:0] sample_reg [2];
    logic [aspdm_pkg::PROD_BITS-1:0]          prod_reg   [2];
    logic [1:0]                               dneg_reg;
    logic [aspdm_pkg::GP_BITS-1:0]            gp_reg     [2];
    logic [1:0]                               fneg_reg;

    logic signed [aspdm_pkg::SAMPLE_BITS-1:0] in_sample [3];
    logic [aspdm_pkg::PEAK_BITS-1:0]          in_abs    [3];
    logic [aspdm_pkg::PEAK_BITS-1:0]          peak_base [3];
    logic [aspdm_pkg::PEAK_BITS-1:0]          peak_next [3];
    logic signed [aspdm_pkg::DIFF_BITS-1:0]   diff      [2];
    logic [aspdm_pkg::DIFF_BITS-1:0]          diff_mag  [2];
    logic [aspdm_pkg::PROD_BITS-1:0]          prod_next [2];
    logic [aspdm_pkg::STEP_BITS-1:0]          step_up   [2];
    logic [aspdm_pkg::STEP_BITS-1:0]          step_dn   [2];
    logic signed [aspdm_pkg::FILT_BITS-1:0]   filt_next [2];
    logic [aspdm_pkg::FILT_BITS-1:0]          filt_mag  [2];
    logic [aspdm_pkg::GP_BITS-1:0]            gp_next   [2];
    logic [aspdm_pkg::PIX_BITS-1:0]           pix       [2];
    logic [aspdm_pkg::LIMIT_BITS-1:0]         pix_clamp [2];
    logic signed [aspdm_pkg::OFFSET_BITS-1:0] offset    [2];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            in_sample[i] = $signed(s_tdata[i*aspdm_pkg::SAMPLE_BITS +: aspdm_pkg::SAMPLE_BITS]);
            in_abs[i]    = aspdm_pkg::abs_sat(in_sample[i]);
            // clear first, then compare
            peak_base[i] = s_tuser ? '0 : peak_reg[i];
            peak_next[i] = (in_abs[i] > peak_base[i]) ? in_abs[i] : peak_base[i];
        end
        for (int i = 0; i < 2; i++)
        begin
            diff[i] = $signed({sample_reg[i][aspdm_pkg::SAMPLE_BITS-1], sample_reg[i],
                               {aspdm_pkg::FILTER_EXTRA_BITS{1'b0}}})
                    - $signed({filt_reg[i][aspdm_pkg::FILT_BITS-1], filt_reg[i]});
            diff_mag[i] = diff[i][aspdm_pkg::DIFF_BITS-1] ? $unsigned(-diff[i])
                                                           : $unsigned(diff[i]);
            prod_next[i] = aspdm_pkg::PROD_BITS'(diff_mag[i])
                         * aspdm_pkg::PROD_BITS'(weight);
            step_up[i] = aspdm_pkg::STEP_BITS'(prod_reg[i] >> aspdm_pkg::WEIGHT_BITS);
            // a falling step rounds away from zero, so the sum stays floored
            step_dn[i] = aspdm_pkg::STEP_BITS'(({1'b0, prod_reg[i]}
                         + (aspdm_pkg::PROD_BITS+1)'(aspdm_pkg::WEIGHT_ROUND))
                         >> aspdm_pkg::WEIGHT_BITS);
            filt_next[i] = dneg_reg[i]
                ? filt_reg[i] - $signed(step_dn[i][aspdm_pkg::FILT_BITS-1:0])
                : filt_reg[i] + $signed(step_up[i][aspdm_pkg::FILT_BITS-1:0]);
            filt_mag[i] = filt_reg[i][aspdm_pkg::FILT_BITS-1] ? $unsigned(-filt_reg[i])
                                                              : $unsigned(filt_reg[i]);
            gp_next[i] = aspdm_pkg::GP_BITS'(filt_mag[i]) * aspdm_pkg::GP_BITS'(gain);
            pix[i] = gp_reg[i][aspdm_pkg::GP_BITS-1:aspdm_pkg::OFFSET_SHIFT];
            pix_clamp[i] = (pix[i] > aspdm_pkg::PIX_BITS'(limit)) ? limit
                                                                  : pix[i][aspdm_pkg::LIMIT_BITS-1:0];
            offset[i] = fneg_reg[i] ? -$signed({1'b0, pix_clamp[i]})
                                    : $signed({1'b0, pix_clamp[i]});
        end
    end

    assign s_tready = (state_reg == F_IDLE);
    assign q_valid  = (state_reg == F_PUSH);

    always_comb
    begin
        q_data.peak_abs_x = peak_reg[0];
        q_data.peak_abs_y = peak_reg[1];
        q_data.peak_abs_z = peak_reg[2];
        q_data.offset_x   = offset[0];
        q_data.offset_y   = offset[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            for (int i = 0; i < 3; i++)
            begin
                peak_reg[i] <= '0;
            end
            for (int i = 0; i < 2; i++)
            begin
                filt_reg[i] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            peak_reg[i] <= peak_next[i];
                        end
                        state_reg <= F_MUL;
                    end
                end
                F_MUL:
                begin
                    state_reg <= F_UPD;
                end
                F_UPD:
                begin
                    for (int i = 0; i < 2; i++)
                    begin
                        filt_reg[i] <= filt_next[i];
                    end
                    state_reg <= F_GAIN;
                end
                F_GAIN:
                begin
                    state_reg <= F_PUSH;
                end
                F_PUSH:
                begin
                    // hold until the queue takes the request
                    if (q_ready)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            sample_reg[0] <= in_sample[0];
            sample_reg[1] <= in_sample[1];
        end
        if (state_reg == F_MUL)
        begin
            for (int i = 0; i < 2; i++)
            begin
                prod_reg[i] <= prod_next[i];
                dneg_reg[i] <= diff[i][aspdm_pkg::DIFF_BITS-1];
            end
        end
        if (state_reg == F_GAIN)
        begin
            for (int i = 0; i < 2; i++)
            begin
                gp_reg[i]   <= gp_next[i];
                fneg_reg[i] <= filt_reg[i][aspdm_pkg::FILT_BITS-1];
            end
        end
    end

endmodule

[rtl/aspdm_queue.sv]
// Two-entry request queue between the front end and the colour back end.
module aspdm_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  aspdm_pkg::entry_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output aspdm_pkg::entry_t out_data
);

    aspdm_pkg::entry_t entry_reg [aspdm_pkg::QUEUE_DEPTH];

    logic [aspdm_pkg::QPTR_BITS-1:0]   wr_ptr_reg;
    logic [aspdm_pkg::QPTR_BITS-1:0]   rd_ptr_reg;
    logic [aspdm_pkg::QCOUNT_BITS-1:0] count_reg;
    logic                              push;
    logic                              pop;

    assign in_ready  = (count_reg != aspdm_pkg::QCOUNT_BITS'(aspdm_pkg::QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

[rtl/aspdm_back.sv]
// Back end: colour pair from the offset length by a bitwise search, and the output register.
module aspdm_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_valid,
    output logic                             q_ready,
    input  aspdm_pkg::entry_t                q_data,
    input  logic [aspdm_pkg::LIMIT_BITS-1:0] limit,
    output logic                             m_valid,
    input  logic                             m_ready,
    output aspdm_pkg::result_t               m_data
);

    typedef enum logic [2:0] {
        B_IDLE, B_SQ, B_RHS, B_PROD, B_TEST, B_EQP, B_EQT, B_OUT
    } bstate_t;

    bstate_t                              state_reg;
    logic                                 m_valid_reg;
    aspdm_pkg::result_t                   m_data_reg;

    aspdm_pkg::entry_t                    entry_reg;
    logic [aspdm_pkg::SUM_BITS-1:0]       sum_reg;
    logic [aspdm_pkg::RHS_BITS-1:0]       rhs_reg;
    logic [aspdm_pkg::CPROD_BITS-1:0]     prod_reg;
    logic [aspdm_pkg::COLOR_BITS-1:0]     r_reg;
    logic [aspdm_pkg::RBIT_BITS-1:0]      bit_reg;
    logic                                 eq_reg;

    logic [aspdm_pkg::LIMIT_BITS-1:0]     mag_x;
    logic [aspdm_pkg::LIMIT_BITS-1:0]     mag_y;
    logic [aspdm_pkg::SUM_BITS-1:0]       sum_next;
    logic [aspdm_pkg::COLOR_BITS-1:0]     cand;
    logic [aspdm_pkg::COLOR_BITS-1:0]     mul_a;
    logic [aspdm_pkg::CPROD_BITS-1:0]     prod_next;
    logic [aspdm_pkg::CSQ_BITS-1:0]       prod_sq;
    logic                                 fits;
    logic [aspdm_pkg::COLOR_BITS-1:0]     red;
    logic [aspdm_pkg::COLOR_BITS-1:0]     green;
    logic                                 out_free;

    always_comb
    begin
        mag_x = entry_reg.offset_x[aspdm_pkg::OFFSET_BITS-1]
              ? aspdm_pkg::LIMIT_BITS'($unsigned(-entry_reg.offset_x))
              : aspdm_pkg::LIMIT_BITS'($unsigned(entry_reg.offset_x));
        mag_y = entry_reg.offset_y[aspdm_pkg::OFFSET_BITS-1]
              ? aspdm_pkg::LIMIT_BITS'($unsigned(-entry_reg.offset_y))
              : aspdm_pkg::LIMIT_BITS'($unsigned(entry_reg.offset_y));
        sum_next = aspdm_pkg::SUM_BITS'(aspdm_pkg::SQ_BITS'(mag_x) * aspdm_pkg::SQ_BITS'(mag_x))
                 + aspdm_pkg::SUM_BITS'(aspdm_pkg::SQ_BITS'(mag_y) * aspdm_pkg::SQ_BITS'(mag_y));

        cand      = r_reg | (aspdm_pkg::COLOR_BITS'(1) << bit_reg);
        mul_a     = (state_reg == B_EQP) ? r_reg : cand;
        prod_next = aspdm_pkg::CPROD_BITS'(mul_a) * aspdm_pkg::CPROD_BITS'(limit);
        prod_sq   = aspdm_pkg::CSQ_BITS'(prod_reg) * aspdm_pkg::CSQ_BITS'(prod_reg);
        fits      = (aspdm_pkg::RHS_BITS'(prod_sq) <= rhs_reg);

        if (limit == '0)
        begin
            red   = '0;
            green = aspdm_pkg::COLOR_BITS'(aspdm_pkg::COLOR_MAX);
        end
        else
        begin
            red = r_reg;
            if (r_reg == aspdm_pkg::COLOR_BITS'(aspdm_pkg::COLOR_MAX))
            begin
                green = '0;
            end
            else if (eq_reg)
            begin
                green = aspdm_pkg::COLOR_BITS'(aspdm_pkg::COLOR_MAX) - r_reg;
            end
            else
            begin
                green = aspdm_pkg::COLOR_BITS'(aspdm_pkg::COLOR_MAX - 1) - r_reg;
            end
        end
    end

    assign q_ready  = (state_reg == B_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            // load a new result when the register frees, else drop the one taken
            if (state_reg == B_OUT && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_valid_reg && m_ready)
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE:
                begin
                    if (q_valid)
                    begin
                        state_reg <= B_SQ;
                    end
                end
                B_SQ:
                begin
                    state_reg <= B_RHS;
                end
                B_RHS:
                begin
                    state_reg <= B_PROD;
                end
                B_PROD:
                begin
                    state_reg <= B_TEST;
                end
                B_TEST:
                begin
                    state_reg <= (bit_reg == '0) ? B_EQP : B_PROD;
                end
                B_EQP:
                begin
                    state_reg <= B_EQT;
                end
                B_EQT:
                begin
                    state_reg <= B_OUT;
                end
                B_OUT:
                begin
                    // hold the result until the output register is free
                    if (out_free)
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    entry_reg <= q_data;
                end
            end
            B_SQ:
            begin
                sum_reg <= sum_next;
            end
            B_RHS:
            begin
                rhs_reg <= aspdm_pkg::RHS_BITS'(sum_reg)
                         * aspdm_pkg::RHS_BITS'(aspdm_pkg::COLOR_MAX_SQ);
                r_reg   <= '0;
                bit_reg <= aspdm_pkg::RBIT_BITS'(aspdm_pkg::COLOR_BITS - 1);
            end
            B_PROD, B_EQP:
            begin
                prod_reg <= prod_next;
            end
            B_TEST:
            begin
                // keep the candidate bit while its square stays within range
                if (fits)
                begin
                    r_reg <= cand;
                end
                bit_reg <= bit_reg - 1'b1;
            end
            B_EQT:
            begin
                eq_reg <= (aspdm_pkg::RHS_BITS'(prod_sq) == rhs_reg);
            end
            B_OUT:
            begin
                if (out_free)
                begin
                    m_data_reg.peak_abs_x  <= entry_reg.peak_abs_x;
                    m_data_reg.peak_abs_y  <= entry_reg.peak_abs_y;
                    m_data_reg.peak_abs_z  <= entry_reg.peak_abs_z;
                    m_data_reg.offset_x    <= entry_reg.offset_x;
                    m_data_reg.offset_y    <= entry_reg.offset_y;
                    m_data_reg.color_red   <= red;
                    m_data_reg.color_green <= green;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

[rtl/accel_smooth_peak_display_map_top.sv]
// Top level: configuration registers, front end, request queue, colour back end, checks.
//
// Takes one three-axis sample per request and returns one result per request: the held
// absolute peaks, the smoothed and clamped X/Y dot offsets and a red/green colour pair.
// The front end steps through accept, weight multiply, filter update, gain multiply and
// hand-off for each sample and takes no new sample until the hand-off; the back end's work
// is the eight-step bitwise search for the colour ratio, each step passing through its
// multiplier pair. A two-entry queue sits between the two halves and the output
// register lets the back end start the next sample while a result waits to be taken.
module accel_smooth_peak_display_map_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // accel_x, accel_y, accel_z
    input  logic [aspdm_pkg::IN_DATA_BITS-1:0]    s_tdata,
    // clear_peaks
    input  logic                                  s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // peak_abs_x, peak_abs_y, peak_abs_z, offset_x, offset_y, color_red, color_green
    output logic [aspdm_pkg::OUT_DATA_BITS-1:0]   m_tdata,
    input  logic                                  cfg_we,
    input  logic [aspdm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [aspdm_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    logic [aspdm_pkg::WEIGHT_BITS-1:0] weight_reg;
    logic [aspdm_pkg::GAIN_BITS-1:0]   gain_reg;
    logic [aspdm_pkg::LIMIT_BITS-1:0]  limit_reg;

    logic               fq_valid;
    logic               fq_ready;
    aspdm_pkg::entry_t  fq_data;
    logic               qb_valid;
    logic               qb_ready;
    aspdm_pkg::entry_t  qb_data;
    aspdm_pkg::result_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= aspdm_pkg::WEIGHT_RESET;
            gain_reg   <= aspdm_pkg::GAIN_RESET;
            limit_reg  <= aspdm_pkg::LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                aspdm_pkg::CFG_WEIGHT:
                begin
                    weight_reg <= cfg_data[aspdm_pkg::WEIGHT_BITS-1:0];
                end
                aspdm_pkg::CFG_GAIN:
                begin
                    gain_reg <= cfg_data[aspdm_pkg::GAIN_BITS-1:0];
                end
                aspdm_pkg::CFG_LIMIT:
                begin
                    limit_reg <= cfg_data[aspdm_pkg::LIMIT_BITS-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    aspdm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .weight   (weight_reg),
        .gain     (gain_reg),
        .limit    (limit_reg),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_data   (fq_data)
    );

    aspdm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    aspdm_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (qb_valid),
        .q_ready (qb_ready),
        .q_data  (qb_data),
        .limit   (limit_reg),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_data  (res)
    );

    assign m_tdata = aspdm_pkg::OUT_DATA_BITS'(res);

    // the front end works on one sample at a time
    a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("front end accepted a request while still busy");

    a_offset_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (res.offset_x <= $signed({1'b0, limit_reg}))
                  && (res.offset_x >= -$signed({1'b0, limit_reg}))
                  && (res.offset_y <= $signed({1'b0, limit_reg}))
                  && (res.offset_y >= -$signed({1'b0, limit_reg})))
        else $error("offset outside the clamp bound");

    // red and green split the full scale, one short when the ratio is not exact
    a_color_pair: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((9'(res.color_red) + 9'(res.color_green)) == 9'd255)
                  || ((9'(res.color_red) + 9'(res.color_green)) == 9'd254))
        else $error("colour pair out of step");

endmodule
